FILE: rtl/core/sled_pkg.sv
`timescale 1ns / 1ps

package sled_pkg;

  // largest byte count the length field must hold
  localparam int unsigned MaxStringDef = 4096;

  // results that one character can cause, and result queue depth
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned FifoDepth = 4;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StUnknown = 2'd1;
  localparam logic [1:0] StBadHex  = 2'd2;
  localparam logic [1:0] StUnterm  = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       ret;
    logic       last;
  } sled_res_t;

endpackage

FILE: rtl/core/sled_core.sv
`timescale 1ns / 1ps

module sled_core #(
  parameter int unsigned MaxString = sled_pkg::MaxStringDef,
  parameter int unsigned LenW      = $clog2(MaxString + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          in_char_i,
  input  logic                start_req_i,
  output logic [1:0]          num_o,
  output sled_pkg::sled_res_t res_o [sled_pkg::MaxRes],
  output logic [LenW-1:0]     len_o [sled_pkg::MaxRes]
);
  import sled_pkg::*;

  typedef enum logic [2:0] {
    ModeDone  = 3'd0,
    ModeText  = 3'd1,
    ModeQuote = 3'd2,
    ModeEsc   = 3'd3,
    ModeOct1  = 3'd4,
    ModeOct2  = 3'd5,
    ModeHex0  = 3'd6,
    ModeHex1  = 3'd7
  } mode_e;

  mode_e           mode_q, mode_d, mode_cur;
  logic [8:0]      accum_q, accum_d, accum_cur;
  logic [LenW-1:0] cnt_q, cnt_d, run;
  logic [1:0]      num;
  logic            do_text;
  logic            octal;
  logic            is_hex;
  logic [3:0]      hex_val;
  logic [7:0]      lower;
  sled_res_t       res [MaxRes];

  function automatic sled_res_t mk_res(logic kind, logic [7:0] data, logic [1:0] status,
                                       logic ret);
    sled_res_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = status;
    r.ret    = ret;
    r.last   = 1'b0;
    return r;
  endfunction

  assign octal = (in_char_i >= "0") && (in_char_i <= "7");
  assign lower = in_char_i | 8'h20;

  always_comb begin
    is_hex  = 1'b0;
    hex_val = '0;
    if ((in_char_i >= "0") && (in_char_i <= "9")) begin
      is_hex  = 1'b1;
      hex_val = 4'(in_char_i - "0");
    end else if ((lower >= "a") && (lower <= "f")) begin
      is_hex  = 1'b1;
      hex_val = 4'(lower - "a" + 8'd10);
    end
  end

  always_comb begin
    mode_cur  = start_req_i ? ModeText : mode_q;
    accum_cur = start_req_i ? '0 : accum_q;
    mode_d    = mode_cur;
    accum_d   = accum_cur;
    num       = '0;
    do_text   = 1'b0;
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '0;
    end

    unique case (mode_cur)
      ModeDone: begin
      end
      ModeText: begin
        do_text = 1'b1;
      end
      ModeQuote: begin
        if (in_char_i == "\"") begin
          mode_d = ModeText;
          res[num] = mk_res(KindData, "\"", StOk, 1'b0);
          num = num + 2'd1;
        end else begin
          mode_d = ModeDone;
          res[num] = mk_res(KindEnd, 8'h00, StOk, 1'b1);
          num = num + 2'd1;
        end
      end
      ModeEsc: begin
        mode_d = ModeText;
        unique case (in_char_i)
          "a":  begin res[num] = mk_res(KindData, 8'd7,  StOk, 1'b0); num = num + 2'd1; end
          "b":  begin res[num] = mk_res(KindData, 8'd8,  StOk, 1'b0); num = num + 2'd1; end
          "f":  begin res[num] = mk_res(KindData, 8'd12, StOk, 1'b0); num = num + 2'd1; end
          "n":  begin res[num] = mk_res(KindData, 8'd10, StOk, 1'b0); num = num + 2'd1; end
          "r":  begin res[num] = mk_res(KindData, 8'd13, StOk, 1'b0); num = num + 2'd1; end
          "t":  begin res[num] = mk_res(KindData, 8'd9,  StOk, 1'b0); num = num + 2'd1; end
          "v":  begin res[num] = mk_res(KindData, 8'd11, StOk, 1'b0); num = num + 2'd1; end
          "\\", "\"": begin
            res[num] = mk_res(KindData, in_char_i, StOk, 1'b0);
            num = num + 2'd1;
          end
          "x":  mode_d = ModeHex0;
          default: begin
            if (octal) begin
              accum_d = 9'(in_char_i - "0");
              mode_d  = ModeOct1;
            end else begin
              res[num] = mk_res(KindData, in_char_i, StUnknown, 1'b0);
              num = num + 2'd1;
              // line end right after a backslash still ends the string
              do_text = (in_char_i == 8'h00);
            end
          end
        endcase
      end
      ModeOct1: begin
        if (octal) begin
          accum_d = 9'({accum_cur, 3'b000} + 12'(in_char_i - "0"));
          mode_d  = ModeOct2;
        end else begin
          mode_d = ModeText;
          res[num] = mk_res(KindData, accum_cur[7:0], StOk, 1'b0);
          num = num + 2'd1;
          do_text = 1'b1;
        end
      end
      ModeOct2: begin
        mode_d = ModeText;
        if (octal) begin
          res[num] = mk_res(KindData, 8'({accum_cur[4:0], 3'b000} + 8'(in_char_i - "0")),
                            StOk, 1'b0);
          num = num + 2'd1;
        end else begin
          res[num] = mk_res(KindData, accum_cur[7:0], StOk, 1'b0);
          num = num + 2'd1;
          do_text = 1'b1;
        end
      end
      ModeHex0: begin
        if (is_hex) begin
          accum_d = 9'(hex_val);
          mode_d  = ModeHex1;
        end else begin
          mode_d = ModeText;
          res[num] = mk_res(KindData, "x", StBadHex, 1'b0);
          num = num + 2'd1;
          res[num] = mk_res(KindData, "x", StOk, 1'b0);
          num = num + 2'd1;
          do_text = 1'b1;
        end
      end
      ModeHex1: begin
        mode_d = ModeText;
        if (is_hex) begin
          res[num] = mk_res(KindData, {accum_cur[3:0], hex_val}, StOk, 1'b0);
          num = num + 2'd1;
        end else begin
          res[num] = mk_res(KindData, accum_cur[7:0], StBadHex, 1'b0);
          num = num + 2'd1;
          do_text = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // plain text handling, also for a character that closed a short escape
    if (do_text) begin
      if (in_char_i == 8'h00) begin
        mode_d = ModeDone;
        res[num] = mk_res(KindEnd, 8'h00, StUnterm, 1'b1);
        num = num + 2'd1;
      end else if (in_char_i == "\"") begin
        mode_d = ModeQuote;
      end else if (in_char_i == "\\") begin
        mode_d = ModeEsc;
      end else begin
        res[num] = mk_res(KindData, in_char_i, StOk, 1'b0);
        num = num + 2'd1;
      end
    end
  end

  // running saturating count across the results of this character
  always_comb begin
    run = start_req_i ? '0 : cnt_q;
    for (int i = 0; i < MaxRes; i++) begin
      res_o[i]      = res[i];
      res_o[i].last = (2'(i) + 2'd1 == num);
      len_o[i]      = '0;
      if (2'(i) < num) begin
        if (res[i].kind == KindEnd) begin
          len_o[i] = run;
        end else if (run < LenW'(MaxString)) begin
          run = run + 1'b1;
        end
      end
    end
    cnt_d = run;
  end

  assign num_o = fire_i ? num : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeDone;
      accum_q <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/sled_rfifo.sv
`timescale 1ns / 1ps

module sled_rfifo #(
  parameter int unsigned LenW = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_num_i,
  input  sled_pkg::sled_res_t push_res_i [sled_pkg::MaxRes],
  input  logic [LenW-1:0]     push_len_i [sled_pkg::MaxRes],
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sled_pkg::sled_res_t out_res_o,
  output logic [LenW-1:0]     out_len_o
);
  import sled_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  sled_res_t       mem_res [FifoDepth];
  logic [LenW-1:0] mem_len [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic            pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  // room for a worst case character is needed before the next transfer in
  assign full_o      = (count_q > CntW'(FifoDepth - MaxRes));
  assign out_res_o   = mem_res[rd_q];
  assign out_len_o   = mem_len[rd_q];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (2'(i) < push_num_i) begin
        mem_res[wr_q + PtrW'(i)] <= push_res_i[i];
        mem_len[wr_q + PtrW'(i)] <= push_len_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PtrW'(push_num_i);
      rd_q    <= rd_q + PtrW'(pop);
      count_q <= count_q + CntW'(push_num_i) - CntW'(pop);
    end
  end

endmodule

FILE: rtl/core/string_literal_escape_decoder.sv
`timescale 1ns / 1ps

// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o | in_char_i, start_req_i
// out     | output    | out_valid_o / out_stall_i | kind_o, out_byte_o, status_o,
//         |           |                         | char_returned_o, length_o, last_o
//
// one character is taken per cycle while in_stall_o is low; its zero to three results land in a four
// entry result queue and leave one per cycle from registers while out_stall_i is low.
// in_stall_o rises while more than one result is still queued, so with the
// output flowing a character with two or three results holds the input until
// at most one result is left queued.
// reset leaves the decoder waiting for a character with start_req_i set.
module string_literal_escape_decoder #(
  parameter int unsigned MaxString = sled_pkg::MaxStringDef,
  parameter int unsigned LenW      = $clog2(MaxString + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_char_i,
  input  logic            start_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            kind_o,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      status_o,
  output logic            char_returned_o,
  output logic [LenW-1:0] length_o,
  output logic            last_o
);
  import sled_pkg::*;

  logic            fire;
  logic            full;
  logic [1:0]      push_num;
  sled_res_t       push_res [MaxRes];
  logic [LenW-1:0] push_len [MaxRes];
  sled_res_t       out_res;

  assign in_stall_o = full;
  assign fire       = in_valid_i && !full;

  sled_core #(
    .MaxString(MaxString),
    .LenW     (LenW)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .in_char_i  (in_char_i),
    .start_req_i(start_req_i),
    .num_o      (push_num),
    .res_o      (push_res),
    .len_o      (push_len)
  );

  sled_rfifo #(
    .LenW(LenW)
  ) u_rfifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (push_num),
    .push_res_i (push_res),
    .push_len_i (push_len),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res),
    .out_len_o  (length_o)
  );

  assign kind_o          = out_res.kind;
  assign out_byte_o      = out_res.data;
  assign status_o        = out_res.status;
  assign char_returned_o = out_res.ret;
  assign last_o          = out_res.last;

endmodule

FILE: verif/tb_string_literal_escape_decoder.sv
`timescale 1ns / 1ps

module tb_string_literal_escape_decoder;
  import sled_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;

  typedef enum logic [2:0] {
    MdDone, MdText, MdQuote, MdEsc, MdOct1, MdOct2, MdHex0, MdHex1
  } dec_mode_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic        ret;
    logic [12:0] len;
    logic        last;
  } dec_result_t;

  // tracks decoder state and the results still owed by the block
  class literal_tracker;
    dec_mode_e    mode;
    int unsigned  accum;
    int unsigned  byte_count;
    dec_result_t  pending_results[$];
    dec_result_t  step_res[$];
    int           errors;
    int           consumed;

    function new();
      mode = MdDone;
      accum = 0;
      byte_count = 0;
      errors = 0;
      consumed = 0;
    endfunction

    function void push_data(logic [7:0] b, logic [1:0] st);
      dec_result_t r;
      r = '0;
      r.kind = KindData;
      r.data = b;
      r.status = st;
      step_res.push_back(r);
      if (byte_count < MaxStringDef) byte_count++;
    endfunction

    function void push_end(logic [1:0] st, logic ret);
      dec_result_t r;
      r = '0;
      r.kind = KindEnd;
      r.status = st;
      r.ret = ret;
      r.len = 13'(byte_count);
      step_res.push_back(r);
      mode = MdDone;
    endfunction

    function int hex_val(logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (l >= "a" && l <= "f") return int'(l - "a") + 10;
      return -1;
    endfunction

    function void plain_char(logic [7:0] c);
      if (c == 8'h00) push_end(StUnterm, 1'b1);
      else if (c == ChQuote) mode = MdQuote;
      else if (c == ChBslash) mode = MdEsc;
      else push_data(c, StOk);
    endfunction

    function void escape_char(logic [7:0] c);
      mode = MdText;
      case (c)
        "a": push_data(8'd7, StOk);
        "b": push_data(8'd8, StOk);
        "f": push_data(8'd12, StOk);
        "n": push_data(8'd10, StOk);
        "r": push_data(8'd13, StOk);
        "t": push_data(8'd9, StOk);
        "v": push_data(8'd11, StOk);
        ChBslash, ChQuote: push_data(c, StOk);
        "x": mode = MdHex0;
        default: begin
          if (c >= "0" && c <= "7") begin
            accum = c - "0";
            mode = MdOct1;
          end else begin
            push_data(c, StUnknown);
            // line end after a backslash also ends the string
            if (c == 8'h00) plain_char(c);
          end
        end
      endcase
    endfunction

    function void take_char(logic [7:0] c, logic start);
      bit octal;
      int h;
      dec_result_t r;
      octal = c >= "0" && c <= "7";
      h = hex_val(c);
      step_res.delete();
      if (start || mode != MdDone) consumed++;
      if (start) begin
        mode = MdText;
        accum = 0;
        byte_count = 0;
      end
      case (mode)
        MdText: plain_char(c);
        MdQuote: begin
          if (c == ChQuote) begin
            mode = MdText;
            push_data(ChQuote, StOk);
          end else begin
            push_end(StOk, 1'b1);
          end
        end
        MdEsc: escape_char(c);
        MdOct1: begin
          if (octal) begin
            accum = (accum * 8 + (c - "0")) & 'h1ff;
            mode = MdOct2;
          end else begin
            mode = MdText;
            push_data(8'(accum), StOk);
            plain_char(c);
          end
        end
        MdOct2: begin
          mode = MdText;
          if (octal) begin
            push_data(8'(accum * 8 + (c - "0")), StOk);
          end else begin
            push_data(8'(accum), StOk);
            plain_char(c);
          end
        end
        MdHex0: begin
          if (h >= 0) begin
            accum = h;
            mode = MdHex1;
          end else begin
            mode = MdText;
            push_data("x", StBadHex);
            push_data("x", StOk);
            plain_char(c);
          end
        end
        MdHex1: begin
          mode = MdText;
          if (h >= 0) begin
            push_data(8'(accum * 16 + h), StOk);
          end else begin
            push_data(8'(accum), StBadHex);
            plain_char(c);
          end
        end
        default: ;
      endcase
      if (step_res.size() > 0) begin
        r = step_res.pop_back();
        r.last = 1'b1;
        step_res.push_back(r);
      end
      foreach (step_res[i]) pending_results.push_back(step_res[i]);
    endfunction

    function void field_check(string name, logic [15:0] expv, logic [15:0] actv);
      if (expv !== actv) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expv, actv);
      end
    endfunction

    function void check_output(logic kind, logic [7:0] data, logic [1:0] status,
                               logic ret, logic [12:0] len, logic last);
      dec_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual kind %0d byte %0h",
                 $time, kind, data);
        return;
      end
      e = pending_results.pop_front();
      field_check("kind", 16'(e.kind), 16'(kind));
      field_check("out_byte", 16'(e.data), 16'(data));
      field_check("status", 16'(e.status), 16'(status));
      field_check("char_returned", 16'(e.ret), 16'(ret));
      field_check("length", 16'(e.len), 16'(len));
      field_check("last", 16'(e.last), 16'(last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_char_i;
  logic        start_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [7:0]  out_byte_o;
  logic [1:0]  status_o;
  logic        char_returned_o;
  logic [12:0] length_o;
  logic        last_o;

  literal_tracker tracker = new();
  bit             gaps_on;
  bit             hold_off_req = 1'b0;
  int unsigned    cycle_count = 0;

  string_literal_escape_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_char_i      (in_char_i),
    .start_req_i    (start_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .char_returned_o(char_returned_o),
    .length_o       (length_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("string_literal_escape_decoder regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      tracker.check_output(kind_o, out_byte_o, status_o, char_returned_o, length_o, last_o);
    end
  end

  // receiver pacing, plus the long hold-off on request
  initial begin : rx_pacing
    int stall_left;
    int quiet_left;
    int r;
    bit hold_done;
    stall_left = 0;
    quiet_left = 20;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (quiet_left > 0) begin
        out_stall_i <= 1'b0;
        quiet_left--;
      end else begin
        out_stall_i <= 1'b0;
        r = $urandom_range(0, 99);
        if (r < 55) stall_left = $urandom_range(1, 3);
        else if (r < 60) stall_left = $urandom_range(15, 40);
        else if (r < 90) quiet_left = $urandom_range(0, 6);
        else quiet_left = $urandom_range(30, 120);
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic s);
    int r;
    int n;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 70) begin
        n = (r >= 96) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        in_valid_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    in_char_i   <= c;
    start_req_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_char(c, s);
  endtask

  // sender pauses until every owed result has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_results.size() != 0);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == ChQuote || c == ChBslash);
    return c;
  endfunction

  // one string: start flag on the first character, random text and escapes, then an optional ending
  task automatic gen_string(int max_tokens);
    string       simple_esc;
    string       hex_digits;
    string       known_esc;
    logic [7:0]  seq[$];
    logic [7:0]  c;
    int          n;
    int          sel;
    bit          known;
    simple_esc = "abfnrtv\\\"";
    hex_digits = "0123456789abcdefABCDEF";
    known_esc  = "abfnrtvx\\\"01234567";
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, max_tokens) : $urandom_range(0, 8);
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        seq.push_back(plain_byte());
      end else if (sel < 52) begin
        seq.push_back(ChQuote);
        seq.push_back(ChQuote);
      end else if (sel < 64) begin
        seq.push_back(ChBslash);
        seq.push_back(simple_esc[$urandom_range(0, simple_esc.len() - 1)]);
      end else if (sel < 76) begin
        seq.push_back(ChBslash);
        repeat ($urandom_range(1, 3)) seq.push_back(8'("0" + $urandom_range(0, 7)));
      end else if (sel < 90) begin
        seq.push_back(ChBslash);
        seq.push_back("x");
        repeat ($urandom_range(0, 2)) begin
          seq.push_back(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
        end
      end else begin
        // unknown escape, any byte outside the known set
        do begin
          c = 8'($urandom_range(0, 255));
          known = 1'b0;
          for (int i = 0; i < known_esc.len(); i++) if (known_esc[i] == c) known = 1'b1;
        end while (known);
        seq.push_back(ChBslash);
        seq.push_back(c);
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      seq.push_back(ChQuote);
      do c = 8'($urandom_range(0, 255)); while (c == ChQuote);
      seq.push_back(c);
    end else if (sel < 80) begin
      seq.push_back(8'h00);
    end else if (sel < 88) begin
      seq.push_back(ChBslash);
      seq.push_back(8'h00);
    end
    // otherwise the next start abandons this string
    if (seq.size() == 0) seq.push_back(plain_byte());
    foreach (seq[i]) send_char(seq[i], i == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin : stimulus
    logic [8:0] directed[$];
    directed = '{
      {1'b0, "a"},                                  // ignored before any start
      {1'b1, "A"}, {1'b0, 8'hff},
      {1'b0, ChQuote}, {1'b0, ChQuote},             // doubled quote
      {1'b0, ChBslash}, {1'b0, "n"},
      {1'b0, ChBslash}, {1'b0, "7"}, {1'b0, "7"}, {1'b0, "7"},
      {1'b0, ChBslash}, {1'b0, "4"}, {1'b0, "z"},   // short octal
      {1'b0, ChBslash}, {1'b0, "x"}, {1'b0, "g"},   // bad hex
      {1'b0, ChBslash}, {1'b0, "x"}, {1'b0, "a"},   // single hex digit
      {1'b0, ChQuote}, {1'b0, "q"},                 // closing quote
      {1'b1, "k"}, {1'b1, ChBslash}, {1'b0, 8'h00}, // restart, then line end in escape
      {1'b1, 8'h00},                                // empty string cut by line end
      {1'b0, 8'h55}
    };
    in_valid_i   <= 1'b0;
    in_char_i    <= 8'h00;
    start_req_i  <= 1'b0;
    rst_ni       <= 1'b0;
    gaps_on      = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_char(directed[i][7:0], directed[i][8]);
    drain();

    while (tracker.consumed < 220) begin
      gaps_on = $urandom_range(0, 4) != 0;
      gen_string(40);
    end
    // receiver holds off while transfers keep coming
    hold_off_req = 1'b1;
    gaps_on = 1'b0;
    while (tracker.consumed < 290) gen_string(40);
    drain();
    while (tracker.consumed < 455) begin
      gaps_on = $urandom_range(0, 4) != 0;
      gen_string(40);
    end
    drain();

    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("string_literal_escape_decoder regression: pass");
    end else begin
      $display("string_literal_escape_decoder regression: fail");
    end
    $finish;
  end

endmodule
